### sv/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg: shared types and code table for the morse timing encoder
// Holds the unit pattern table, its widths and the character code constants.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int PatW     = 19;             // longest element pattern (digit 0)
  localparam int GapUnits = 3;              // key-up units after every character
  localparam int UnitW    = PatW + GapUnits;
  localparam int LenW     = $clog2(PatW + 1);
  localparam int CntW     = $clog2(UnitW + 1);

  localparam logic [7:0] CodeLowA  = 8'h61;
  localparam logic [7:0] CodeLowZ  = 8'h7a;
  localparam logic [7:0] CodeZero  = 8'h30;
  localparam logic [7:0] CodeNine  = 8'h39;
  localparam logic [7:0] CodeSpace = 8'h20;

  // pattern left-justified in bits, MSB goes out first
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } morse_entry_t;

  function automatic morse_entry_t morse_lookup(input logic [7:0] code);
    morse_entry_t e;
    e.len  = '0;
    e.bits = '0;
    case (code)
      8'h61: e = '{5'd5,  {5'b10111, 14'd0}};
      8'h62: e = '{5'd9,  {9'b111010101, 10'd0}};
      8'h63: e = '{5'd11, {11'b11101011101, 8'd0}};
      8'h64: e = '{5'd7,  {7'b1110101, 12'd0}};
      8'h65: e = '{5'd1,  {1'b1, 18'd0}};
      8'h66: e = '{5'd9,  {9'b101011101, 10'd0}};
      8'h67: e = '{5'd9,  {9'b111011101, 10'd0}};
      8'h68: e = '{5'd7,  {7'b1010101, 12'd0}};
      8'h69: e = '{5'd3,  {3'b101, 16'd0}};
      8'h6a: e = '{5'd13, {13'b1011101110111, 6'd0}};
      8'h6b: e = '{5'd9,  {9'b111010111, 10'd0}};
      8'h6c: e = '{5'd9,  {9'b101110101, 10'd0}};
      8'h6d: e = '{5'd7,  {7'b1110111, 12'd0}};
      8'h6e: e = '{5'd5,  {5'b11101, 14'd0}};
      8'h6f: e = '{5'd11, {11'b11101110111, 8'd0}};
      8'h70: e = '{5'd11, {11'b10111011101, 8'd0}};
      8'h71: e = '{5'd13, {13'b1110111010111, 6'd0}};
      8'h72: e = '{5'd7,  {7'b1011101, 12'd0}};
      8'h73: e = '{5'd5,  {5'b10101, 14'd0}};
      8'h74: e = '{5'd3,  {3'b111, 16'd0}};
      8'h75: e = '{5'd7,  {7'b1010111, 12'd0}};
      8'h76: e = '{5'd9,  {9'b101010111, 10'd0}};
      8'h77: e = '{5'd9,  {9'b101110111, 10'd0}};
      8'h78: e = '{5'd11, {11'b11101010111, 8'd0}};
      8'h79: e = '{5'd13, {13'b1110101110111, 6'd0}};
      8'h7a: e = '{5'd11, {11'b11101110101, 8'd0}};
      8'h30: e = '{5'd19, 19'b1110111011101110111};
      8'h31: e = '{5'd17, {17'b10111011101110111, 2'd0}};
      8'h32: e = '{5'd15, {15'b101011101110111, 4'd0}};
      8'h33: e = '{5'd13, {13'b1010101110111, 6'd0}};
      8'h34: e = '{5'd11, {11'b10101010111, 8'd0}};
      8'h35: e = '{5'd9,  {9'b101010101, 10'd0}};
      8'h36: e = '{5'd11, {11'b11101010101, 8'd0}};
      8'h37: e = '{5'd13, {13'b1110111010101, 6'd0}};
      8'h38: e = '{5'd15, {15'b111011101110101, 4'd0}};
      8'h39: e = '{5'd17, {17'b11101110111011101, 2'd0}};
      CodeSpace: e = '{5'd3, 19'd0};
      default: e = '{5'd0, 19'd0};
    endcase
    return e;
  endfunction

endpackage

### sv/morse_timing_encoder.sv
// ----------------------------------------------------------------------------
// morse_timing_encoder
// Turns each accepted character code into its Morse key timing, one unit
// per output beat, with a last flag on the final unit of each character.
// ----------------------------------------------------------------------------
// Each accepted character is looked up in a constant table and loaded into a
// 22-bit shift register together with its unit count; one unit leaves per
// output beat from the register's top bit. A character has as many units
// as its pattern length plus the 3-unit gap: 3 for an unmapped code, 6 for
// a space, up to 22 for the digit 0. The next character is taken in the
// same cycle as the last unit of the current one leaves, so with a ready
// sink the output runs without bubbles.
module morse_timing_encoder
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_key_bit,
  output logic       out_last_unit
);

  logic [UnitW-1:0] shift_r, shift_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  morse_entry_t     entry;
  logic             in_fire, out_fire;

  assign entry     = morse_lookup(in_char_code);
  assign out_valid = (cnt_r != '0);
  assign out_key_bit   = shift_r[UnitW-1];
  assign out_last_unit = (cnt_r == CntW'(1));
  assign out_fire  = out_valid && out_ready;
  // free when empty, or when the final unit leaves this cycle
  assign in_ready  = !out_valid || (out_last_unit && out_ready);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    if (out_fire) begin
      shift_nxt = {shift_r[UnitW-2:0], 1'b0};
      cnt_nxt   = cnt_r - CntW'(1);
    end
    if (in_fire) begin
      shift_nxt = {entry.bits, GapUnits'(0)};
      cnt_nxt   = CntW'(entry.len) + CntW'(GapUnits);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

`ifndef SYNTHESIS
  // the closing unit of every character is always key up
  a_last_key_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_unit |-> !out_key_bit)
    else $error("last unit of a character is key down");

  // a new character always brings at least the gap units
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && (cnt_r >= CntW'(GapUnits)))
    else $error("loaded character has too few units");

  // no hole inside a character
  a_no_hole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_unit |=> out_valid)
    else $error("output went idle inside a character");

  // input taken only when the current character is finishing or done
  a_ready_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> (cnt_r == '0) || (out_last_unit && out_ready))
    else $error("input accepted while a character is in progress");
`endif

endmodule
